// ===== src/tstt_pkg.sv =====
`default_nettype none

package tstt_pkg;

   localparam int N_WEEKDAYS      = 7;
   localparam int N_WEEKS         = 5;
   localparam int N_HOURS         = 24;
   localparam int N_MINUTES       = 60;
   localparam int MONTH_SLOTS_DEF = 5;

   localparam int CNT_W  = 18;
   localparam int CONG_W = 11;
   localparam int HOUR_W = 5;

   typedef logic [1:0] op_type;
   typedef logic [2:0] code_type;

   localparam op_type OP_RECORD  = 2'd0;
   localparam op_type OP_WEEKDAY = 2'd1;
   localparam op_type OP_HOURLY  = 2'd2;
   localparam op_type OP_TOTAL   = 2'd3;

   localparam code_type CODE_UNSET  = 3'd0;
   localparam code_type CODE_GREEN  = 3'd1;
   localparam code_type CODE_YELLOW = 3'd2;
   localparam code_type CODE_RED    = 3'd3;
   localparam code_type CODE_BLACK  = 3'd4;

   localparam int N_CODES = 5;

   // week of month from the calendar day
   function automatic logic [2:0] week_bin(input logic [4:0] day);
      logic [2:0] wb;
      if (day >= 5'd8 && day <= 5'd14) begin
         wb = 3'd1;
      end else if (day >= 5'd15 && day <= 5'd21) begin
         wb = 3'd2;
      end else if (day >= 5'd22 && day <= 5'd28) begin
         wb = 3'd3;
      end else if (day >= 5'd29) begin
         wb = 3'd4;
      end else begin
         wb = 3'd0;
      end
      return wb;
   endfunction

endpackage

`default_nettype wire

// ===== src/tstt_req_if.sv =====
`default_nettype none

interface tstt_req_if;
   logic                valid;
   logic                ready;
   tstt_pkg::op_type    op;
   logic [2:0]          month;
   logic [4:0]          day_of_month;
   logic [4:0]          hour;
   logic [5:0]          minute;
   logic [2:0]          weekday;
   tstt_pkg::code_type  traffic;

   modport source (
      output valid, op, month, day_of_month, hour, minute, weekday, traffic,
      input  ready
   );
   modport sink (
      input  valid, op, month, day_of_month, hour, minute, weekday, traffic,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/tstt_rsp_if.sv =====
`default_nettype none

interface tstt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tstt_pkg::CNT_W-1:0]   count_unset;
   logic [tstt_pkg::CNT_W-1:0]   count_green;
   logic [tstt_pkg::CNT_W-1:0]   count_yellow;
   logic [tstt_pkg::CNT_W-1:0]   count_red;
   logic [tstt_pkg::CNT_W-1:0]   count_black;
   logic [tstt_pkg::CNT_W-1:0]   measure_count;
   logic [tstt_pkg::HOUR_W-1:0]  out_hour;
   logic [tstt_pkg::CONG_W-1:0]  hour_congested;
   logic                         last;

   modport source (
      output valid, count_unset, count_green, count_yellow, count_red, count_black,
             measure_count, out_hour, hour_congested, last,
      input  ready
   );
   modport sink (
      input  valid, count_unset, count_green, count_yellow, count_red, count_black,
             measure_count, out_hour, hour_congested, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/traffic_state_tally_table_top.sv =====
// traffic state tally table
// req_ch carries one item per op: record (op 0) writes one 3-bit state cell,
// weekday stats (op 1), hourly congestion (op 2) and whole-table counts (op 3)
// scan the state memory. rsp_ch returns the query results, last marks the
// final result of an item. both channels use valid/ready.
// the table sits in one single-port-write, registered-read memory of
// 7*MONTH_SLOTS*7200 cells (252000 at the default of 5 month slots).
// after reset the block sweeps the memory to unset, one cell per cycle,
// with req_ch.ready low. one item is in work at a time; req_ch.ready is
// high only when idle. a record is accepted, then written. a weekday
// query scans the MONTH_SLOTS*7200 cells of its weekday through the read
// pipeline, the whole-table query all 7*MONTH_SLOTS*7200 cells; the scan
// reads one cell per cycle through the memory read port. a query with a
// bad weekday skips the scan. results then leave one per cycle while
// rsp_ch.ready is high: one result for ops 1 and 3, 24 for op 2.
// a stalled receiver holds the current result on rsp_ch until it is taken.
`default_nettype none

module traffic_state_tally_table_top #(
   parameter int MONTH_SLOTS = tstt_pkg::MONTH_SLOTS_DEF
) (
   input wire         clock,
   input wire         reset,
   tstt_req_if.sink   req_ch,
   tstt_rsp_if.source rsp_ch
);

   localparam int HBLK    = tstt_pkg::N_HOURS * tstt_pkg::N_MINUTES;
   localparam int MBLK    = tstt_pkg::N_WEEKS * HBLK;
   localparam int CPW     = MONTH_SLOTS * MBLK;
   localparam int N_CELLS = tstt_pkg::N_WEEKDAYS * CPW;
   localparam int ADDR_W  = $clog2(N_CELLS);
   localparam int CNT_W   = tstt_pkg::CNT_W;
   localparam int CONG_W  = tstt_pkg::CONG_W;
   localparam int HOUR_W  = tstt_pkg::HOUR_W;
   localparam int NH      = tstt_pkg::N_HOURS;
   localparam int NC      = tstt_pkg::N_CODES;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_REC   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // state memory
   tstt_pkg::code_type mem [N_CELLS];

   // control
   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic [5:0]        min_ff, min_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [HOUR_W-1:0] out_idx_ff, out_idx_in;

   // payload
   tstt_pkg::op_type   op_ff, op_in;
   tstt_pkg::code_type traffic_ff, traffic_in;
   logic               rec_ok_ff, rec_ok_in;
   logic [ADDR_W-1:0]  addr_hi_ff, addr_hi_in;
   logic [ADDR_W-1:0]  addr_lo_ff, addr_lo_in;
   logic [5:0]         rd_min_ff;
   tstt_pkg::code_type rd_data_ff;
   logic [CNT_W-1:0]   cnt_ff [NC];
   logic [CNT_W-1:0]   cnt_in [NC];
   logic [CNT_W-1:0]   meas_ff, meas_in;
   logic [CONG_W-1:0]  tally_ff [NH];
   logic [CONG_W-1:0]  tally_in [NH];

   logic               req_fire;
   logic               rsp_fire;
   logic               rsp_last;
   logic               wd_ok;
   logic [ADDR_W-1:0]  base_wd;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   tstt_pkg::code_type mem_wdata;
   logic               hit;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign rsp_fire     = rsp_ch.valid & rsp_ch.ready;
   assign rsp_last     = (op_ff != tstt_pkg::OP_HOURLY) ||
                         (out_idx_ff == HOUR_W'(NH - 1));

   assign wd_ok   = (req_ch.weekday < 3'(tstt_pkg::N_WEEKDAYS));
   assign base_wd = ADDR_W'(req_ch.weekday) * ADDR_W'(CPW);

   assign hit = (op_ff == tstt_pkg::OP_HOURLY) &&
                (rd_data_ff == tstt_pkg::CODE_RED || rd_data_ff == tstt_pkg::CODE_BLACK);

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      rem_in     = rem_ff;
      min_in     = min_ff;
      out_idx_in = out_idx_ff;
      op_in      = op_ff;
      traffic_in = traffic_ff;
      rec_ok_in  = rec_ok_ff;
      addr_hi_in = addr_hi_ff;
      addr_lo_in = addr_lo_ff;
      meas_in    = meas_ff;
      cnt_in     = cnt_ff;
      tally_in   = tally_ff;
      rd_vld_in  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = addr_ff;
      mem_wdata  = tstt_pkg::CODE_UNSET;

      // read pipeline tally, one cell per cycle
      if (rd_vld_ff) begin
         for (int c = 0; c < NC; c++) begin
            if (rd_data_ff == tstt_pkg::code_type'(c)) begin
               cnt_in[c] = cnt_ff[c] + CNT_W'(1);
            end
         end
         // hours come in order, so the ring turns at the end of each hour
         if (rd_min_ff == 6'(tstt_pkg::N_MINUTES - 1)) begin
            for (int h = 0; h < NH - 1; h++) begin
               tally_in[h] = tally_ff[h + 1];
            end
            tally_in[NH - 1] = tally_ff[0] + CONG_W'(hit);
         end else begin
            tally_in[0] = tally_ff[0] + CONG_W'(hit);
         end
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            if (addr_ff == ADDR_W'(N_CELLS - 1)) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_ch.op;
               traffic_in = req_ch.traffic;
               rec_ok_in  = wd_ok && (32'(req_ch.month) < MONTH_SLOTS) &&
                            (req_ch.hour < 5'(tstt_pkg::N_HOURS)) &&
                            (req_ch.minute < 6'(tstt_pkg::N_MINUTES));
               addr_hi_in = base_wd + ADDR_W'(req_ch.month) * ADDR_W'(MBLK);
               addr_lo_in = ADDR_W'(tstt_pkg::week_bin(req_ch.day_of_month)) * ADDR_W'(HBLK)
                          + ADDR_W'(req_ch.hour) * ADDR_W'(tstt_pkg::N_MINUTES)
                          + ADDR_W'(req_ch.minute);
               out_idx_in = '0;
               min_in     = '0;
               for (int c = 0; c < NC; c++) begin
                  cnt_in[c] = '0;
               end
               for (int h = 0; h < NH; h++) begin
                  tally_in[h] = '0;
               end
               if (req_ch.op == tstt_pkg::OP_RECORD) begin
                  state_in = S_REC;
               end else if (req_ch.op == tstt_pkg::OP_TOTAL) begin
                  addr_in  = '0;
                  rem_in   = ADDR_W'(N_CELLS - 1);
                  meas_in  = CNT_W'(N_CELLS);
                  state_in = S_SCAN;
               end else begin
                  addr_in  = base_wd;
                  rem_in   = ADDR_W'(CPW - 1);
                  meas_in  = wd_ok ? CNT_W'(CPW) : '0;
                  state_in = wd_ok ? S_SCAN : S_OUT;
               end
            end
         end
         S_REC: begin
            mem_we    = rec_ok_ff;
            mem_waddr = addr_hi_ff + addr_lo_ff;
            mem_wdata = traffic_ff;
            state_in  = S_IDLE;
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            addr_in   = addr_ff + ADDR_W'(1);
            rem_in    = rem_ff - ADDR_W'(1);
            min_in    = (min_ff == 6'(tstt_pkg::N_MINUTES - 1)) ? '0 : min_ff + 6'd1;
            if (rem_ff == '0) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_fire) begin
               if (rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + HOUR_W'(1);
                  for (int h = 0; h < NH - 1; h++) begin
                     tally_in[h] = tally_ff[h + 1];
                  end
                  tally_in[NH - 1] = tally_ff[0];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         addr_ff    <= '0;
         rem_ff     <= '0;
         min_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         rem_ff     <= rem_in;
         min_ff     <= min_in;
         rd_vld_ff  <= rd_vld_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      traffic_ff <= traffic_in;
      rec_ok_ff  <= rec_ok_in;
      addr_hi_ff <= addr_hi_in;
      addr_lo_ff <= addr_lo_in;
      meas_ff    <= meas_in;
      cnt_ff     <= cnt_in;
      tally_ff   <= tally_in;
      rd_min_ff  <= min_ff;
   end

   // state memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == S_SCAN) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   assign rsp_ch.valid          = (state_ff == S_OUT);
   assign rsp_ch.count_unset    = (op_ff == tstt_pkg::OP_TOTAL) ? cnt_ff[0] : '0;
   assign rsp_ch.count_green    = (op_ff == tstt_pkg::OP_HOURLY) ? '0 : cnt_ff[1];
   assign rsp_ch.count_yellow   = (op_ff == tstt_pkg::OP_HOURLY) ? '0 : cnt_ff[2];
   assign rsp_ch.count_red      = (op_ff == tstt_pkg::OP_HOURLY) ? '0 : cnt_ff[3];
   assign rsp_ch.count_black    = (op_ff == tstt_pkg::OP_HOURLY) ? '0 : cnt_ff[4];
   assign rsp_ch.measure_count  = meas_ff;
   assign rsp_ch.out_hour       = (op_ff == tstt_pkg::OP_HOURLY) ? out_idx_ff : '0;
   assign rsp_ch.hour_congested = (op_ff == tstt_pkg::OP_HOURLY) ? tally_ff[0] : '0;
   assign rsp_ch.last           = rsp_last;

   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == S_SCAN || state_ff == S_DRAIN))
      else $error("read data valid outside a scan");

   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_REC))
      else $error("memory write outside clear or record");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last) |=> (state_ff == S_IDLE && req_ch.ready))
      else $error("block not idle after the final result");

   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (out_idx_ff < HOUR_W'(NH)))
      else $error("result hour index out of range");

endmodule

`default_nettype wire
